[rtl/biq_pkg.sv]
package biq_pkg;

  localparam int unsigned PC_W      = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
  localparam logic [PC_W-1:0] STEP_MB0   = 3'd1;
  localparam logic [PC_W-1:0] STEP_ACCY  = 3'd2;
  localparam logic [PC_W-1:0] STEP_ROUND = 3'd3;
  localparam logic [PC_W-1:0] STEP_MA1   = 3'd4;
  localparam logic [PC_W-1:0] STEP_T     = 3'd5;
  localparam logic [PC_W-1:0] STEP_AF    = 3'd6;
  localparam logic [PC_W-1:0] STEP_AS    = 3'd7;

  typedef enum logic [1:0] {JMP_NONE, JMP_IF_IDLE, JMP_ALWAYS} jmp_e;
  typedef enum logic {MUL_X, MUL_Y} mul_src_e;
  typedef enum logic [2:0] {COEF_B0, COEF_B1, COEF_A1, COEF_B2, COEF_A2} coef_e;
  typedef enum logic [1:0] {ALU_A_ACC, ALU_A_P, ALU_A_PP} alu_a_e;
  typedef enum logic [1:0] {ALU_B_AF, ALU_B_AS, ALU_B_P, ALU_B_RND} alu_b_e;
  typedef enum logic [1:0] {DST_NONE, DST_ACC, DST_AF, DST_AS} alu_dst_e;

  typedef struct packed {
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            mul_en;
    mul_src_e        mul_src;
    coef_e           coef;
    alu_a_e          alu_a;
    alu_b_e          alu_b;
    logic            alu_sub;
    alu_dst_e        alu_dst;
    logic            y_ld;
    logic            out_wr;
  } ucw_t;

  // microprogram: p/pp form a two-deep product history
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '0;
    case (pc)
      STEP_WAIT: begin
        w.jmp    = JMP_IF_IDLE;
        w.target = STEP_WAIT;
      end
      STEP_MB0: begin
        w.mul_en  = 1'b1;
        w.mul_src = MUL_X;
        w.coef    = COEF_B0;
      end
      STEP_ACCY: begin
        w.alu_a   = ALU_A_P;
        w.alu_b   = ALU_B_AF;
        w.alu_dst = DST_ACC;
        w.mul_en  = 1'b1;
        w.mul_src = MUL_X;
        w.coef    = COEF_B1;
      end
      STEP_ROUND: begin
        w.alu_a = ALU_A_ACC;
        w.alu_b = ALU_B_RND;
        w.y_ld  = 1'b1;
      end
      STEP_MA1: begin
        w.mul_en  = 1'b1;
        w.mul_src = MUL_Y;
        w.coef    = COEF_A1;
      end
      STEP_T: begin
        w.alu_a   = ALU_A_PP;
        w.alu_b   = ALU_B_P;
        w.alu_sub = 1'b1;
        w.alu_dst = DST_ACC;
        w.mul_en  = 1'b1;
        w.mul_src = MUL_X;
        w.coef    = COEF_B2;
      end
      STEP_AF: begin
        w.alu_a   = ALU_A_ACC;
        w.alu_b   = ALU_B_AS;
        w.alu_dst = DST_AF;
        w.mul_en  = 1'b1;
        w.mul_src = MUL_Y;
        w.coef    = COEF_A2;
      end
      STEP_AS: begin
        w.alu_a   = ALU_A_PP;
        w.alu_b   = ALU_B_P;
        w.alu_sub = 1'b1;
        w.alu_dst = DST_AS;
        w.out_wr  = 1'b1;
        w.jmp     = JMP_ALWAYS;
        w.target  = STEP_WAIT;
      end
      default: begin
        w.jmp    = JMP_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/biq_seq.sv]
module biq_seq import biq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_busy_i,
  output logic in_ready_o,
  output ucw_t ctl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ucw_t            cw;
  logic            adv;

  assign cw         = ucode(pc_q);
  assign in_ready_o = (cw.jmp == JMP_IF_IDLE);
  assign adv        = !(cw.out_wr && out_busy_i);

  always_comb begin
    case (cw.jmp)
      JMP_IF_IDLE: pc_d = in_valid_i ? pc_q + 1'b1 : cw.target;
      JMP_ALWAYS:  pc_d = cw.target;
      default:     pc_d = pc_q + 1'b1;
    endcase
    if (!adv) begin
      pc_d = pc_q;
    end
  end

  // hold off all writes while the result register is still occupied
  always_comb begin
    ctl_o = cw;
    if (!adv) begin
      ctl_o.mul_en  = 1'b0;
      ctl_o.alu_dst = DST_NONE;
      ctl_o.y_ld    = 1'b0;
      ctl_o.out_wr  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[rtl/biq_dp.sv]
module biq_dp import biq_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned COEFF_WIDTH  = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ucw_t                           ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  logic signed [COEFF_WIDTH-1:0]  b0_i,
  input  logic signed [COEFF_WIDTH-1:0]  b1_i,
  input  logic signed [COEFF_WIDTH-1:0]  a1_i,
  input  logic signed [COEFF_WIDTH-1:0]  b2_i,
  input  logic signed [COEFF_WIDTH-1:0]  a2_i,
  output logic signed [SAMPLE_WIDTH-1:0] y_o
);

  localparam int unsigned AW   = SAMPLE_WIDTH + COEFF_WIDTH;
  localparam int unsigned FRAC = COEFF_WIDTH - 4;
  localparam int unsigned YW   = AW - FRAC;
  localparam logic [AW-1:0] RND     = AW'(1) << (COEFF_WIDTH - 5);
  localparam logic [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] mul_a;
  logic signed [COEFF_WIDTH-1:0]  mul_b;
  logic signed [AW-1:0]           prod;
  logic signed [AW-1:0]           p_q, pp_q, acc_q, af_q, as_q;
  logic signed [AW-1:0]           opa, opb, alu_res;
  logic        [AW:0]             sum_w;
  logic signed [YW-1:0]           ysh;
  logic signed [SAMPLE_WIDTH-1:0] y_q, y_d;

  assign mul_a = (ctl_i.mul_src == MUL_Y) ? y_q : x_i;

  always_comb begin
    case (ctl_i.coef)
      COEF_B0: mul_b = b0_i;
      COEF_B1: mul_b = b1_i;
      COEF_A1: mul_b = a1_i;
      COEF_B2: mul_b = b2_i;
      COEF_A2: mul_b = a2_i;
      default: mul_b = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (ctl_i.alu_a)
      ALU_A_ACC: opa = acc_q;
      ALU_A_P:   opa = p_q;
      ALU_A_PP:  opa = pp_q;
      default:   opa = '0;
    endcase
    case (ctl_i.alu_b)
      ALU_B_AF:  opb = af_q;
      ALU_B_AS:  opb = as_q;
      ALU_B_P:   opb = p_q;
      ALU_B_RND: opb = signed'(RND);
      default:   opb = '0;
    endcase
  end

  // one guard bit, then clamp to the accumulator range
  always_comb begin
    if (ctl_i.alu_sub) begin
      sum_w = {opa[AW-1], opa} - {opb[AW-1], opb};
    end else begin
      sum_w = {opa[AW-1], opa} + {opb[AW-1], opb};
    end
    if (sum_w[AW] != sum_w[AW-1]) begin
      alu_res = sum_w[AW] ? signed'(ACC_MIN) : signed'(ACC_MAX);
    end else begin
      alu_res = signed'(sum_w[AW-1:0]);
    end
  end

  // floor shift to sample format, then clamp
  always_comb begin
    ysh = signed'(alu_res[AW-1:FRAC]);
    if ((&ysh[YW-1:SAMPLE_WIDTH-1]) || !(|ysh[YW-1:SAMPLE_WIDTH-1])) begin
      y_d = ysh[SAMPLE_WIDTH-1:0];
    end else begin
      y_d = ysh[YW-1] ? signed'(Y_MIN) : signed'(Y_MAX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      p_q  <= prod;
      pp_q <= p_q;
    end
    if (ctl_i.alu_dst == DST_ACC) begin
      acc_q <= alu_res;
    end
    if (ctl_i.y_ld) begin
      y_q <= y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      af_q <= '0;
      as_q <= '0;
    end else begin
      if (ctl_i.alu_dst == DST_AF) begin
        af_q <= alu_res;
      end
      if (ctl_i.alu_dst == DST_AS) begin
        as_q <= alu_res;
      end
    end
  end

  assign y_o = y_q;

endmodule

[rtl/biquad_df2t_filter.sv]
// Each accepted input beat runs through steps MB0, ACCY, ROUND, MA1, T, AF and AS of
// the eight-step microprogram, one sample at a time, driving a single shared
// multiplier and a single saturating adder; AS registers the result beat.
// A pending result beat does not block the next input beat; only the final step waits.
// Reset: asynchronous, active low; clears both state accumulators, sets b0 to 1.0
// and the other coefficients to zero, and empties the output register.
module biquad_df2t_filter import biq_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned COEFF_WIDTH  = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata_i,  // sample_in
  input  logic                                 s_axis_tlast_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata_o,  // sample_out
  output logic                                 m_axis_tlast_o,
  input  logic                                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                 cfg_idx_i,
  input  logic [COEFF_WIDTH-1:0]               cfg_wdata_i
);

  localparam logic [COEFF_WIDTH-1:0] B0_RESET = COEFF_WIDTH'(1) << (COEFF_WIDTH - 4);

  logic [COEFF_WIDTH-1:0]  b0_q, b1_q, a1_q, b2_q, a2_q;
  logic [SAMPLE_WIDTH-1:0] x_q;
  logic                    last_q;
  logic                    in_fire;
  logic                    out_busy;
  ucw_t                    ctl;
  logic signed [SAMPLE_WIDTH-1:0] y;
  logic                    m_valid_q;
  logic [SAMPLE_WIDTH-1:0] m_sample_q;
  logic                    m_last_q;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_busy = m_valid_q && !m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= B0_RESET;
      b1_q <= '0;
      a1_q <= '0;
      b2_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_B0:  b0_q <= cfg_wdata_i;
        REG_B1:  b1_q <= cfg_wdata_i;
        REG_A1:  a1_q <= cfg_wdata_i;
        REG_B2:  b2_q <= cfg_wdata_i;
        REG_A2:  a2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q    <= s_axis_tdata_i[SAMPLE_WIDTH-1:0];
      last_q <= s_axis_tlast_i;
    end
    if (ctl.out_wr) begin
      m_sample_q <= y;
      m_last_q   <= last_q;
    end
  end

  biq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_busy_i (out_busy),
    .in_ready_o (s_axis_tready_o),
    .ctl_o      (ctl)
  );

  biq_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEFF_WIDTH  (COEFF_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .x_i    (signed'(x_q)),
    .b0_i   (signed'(b0_q)),
    .b1_i   (signed'(b1_q)),
    .a1_i   (signed'(a1_q)),
    .b2_i   (signed'(b2_q)),
    .a2_i   (signed'(a2_q)),
    .y_o    (y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctl.out_wr) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[SAMPLE_WIDTH-1:0] = m_sample_q;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = m_last_q;

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("input accepted while a sample is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_wr |-> !(m_valid_q && !m_axis_tready_i))
    else $error("result register overwritten before its beat was taken");

  a_wait_not_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !ctl.out_wr)
    else $error("result written from the wait step");

endmodule

[bench/tb_biquad_df2t_filter.sv]
module tb_biquad_df2t_filter import biq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = 24;
  localparam int COEFF_W      = 24;
  localparam int DATA_W       = ((SAMPLE_W + 7) / 8) * 8;
  localparam int ACC_W        = SAMPLE_W + COEFF_W;
  localparam int COEFF_FRAC   = COEFF_W - 4;
  localparam int DRAIN_CYCLES = 12;
  localparam int SETS_PER_RUN = 6;
  localparam int BEATS_PER_SET = 63;

  localparam longint ACC_MAX  = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN  = -ACC_MAX - 1;
  localparam longint SMP_HI   = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SMP_LO   = -SMP_HI - 1;
  localparam longint RND_HALF = longint'(1) <<< (COEFF_FRAC - 1);

  localparam logic [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [COEFF_W-1:0]  CF_MAX  = {1'b0, {(COEFF_W-1){1'b1}}};
  localparam logic [COEFF_W-1:0]  CF_MIN  = {1'b1, {(COEFF_W-1){1'b0}}};
  localparam logic [COEFF_W-1:0]  CF_ONE  = COEFF_W'(1) << COEFF_FRAC;
  localparam logic [COEFF_W-1:0]  CF_HALF = COEFF_W'(1) << (COEFF_FRAC - 1);
  localparam int                  IDX_TOP = (1 << CFG_IDX_W) - 1;

  typedef enum int {SET_WIDE, SET_AUDIO, SET_EXTREME} coeff_set_e;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } filt_out_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [DATA_W-1:0]    s_axis_tdata_i;   // sample_in
  logic                 s_axis_tlast_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [DATA_W-1:0]    m_axis_tdata_o;   // sample_out
  logic                 m_axis_tlast_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COEFF_W-1:0]   cfg_wdata_i;

  logic signed [COEFF_W-1:0] coef_b0, coef_b1, coef_a1, coef_b2, coef_a2;
  longint    acc_first, acc_second;
  filt_out_t pending_outputs[$];
  filt_out_t got_beat;
  int        err_count;
  int        src_idle_pct;
  int        snk_idle_pct;

  biquad_df2t_filter #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .COEFF_WIDTH (COEFF_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic longint acc_sat(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // one DF2T step; the saturated output is what feeds back
  function automatic logic [SAMPLE_W-1:0] filter_predict(input logic signed [SAMPLE_W-1:0] x);
    longint xl, b0, b1, a1, b2, a2, yacc, y, t;
    xl = x;
    b0 = coef_b0;
    b1 = coef_b1;
    a1 = coef_a1;
    b2 = coef_b2;
    a2 = coef_a2;
    yacc = acc_sat(xl * b0 + acc_first);
    yacc = acc_sat(yacc + RND_HALF);
    y = yacc >>> COEFF_FRAC;
    if (y > SMP_HI) y = SMP_HI;
    if (y < SMP_LO) y = SMP_LO;
    t = acc_sat(xl * b1 - a1 * y);
    acc_first  = acc_sat(t + acc_second);
    acc_second = acc_sat(xl * b2 - a2 * y);
    return y[SAMPLE_W-1:0];
  endfunction

  task automatic write_coeff(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_B0:  coef_b0 = val;
      REG_B1:  coef_b1 = val;
      REG_A1:  coef_a1 = val;
      REG_B2:  coef_b2 = val;
      REG_A2:  coef_a2 = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic last);
    filt_out_t beat;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    beat.sample = filter_predict(x);
    beat.last   = last;
    pending_outputs.push_back(beat);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= DATA_W'(x);
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom_range(1) ? SMP_MAX : SMP_MIN;
    if (pick < 30) return SAMPLE_W'($urandom_range(8191) - 4096);
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic [COEFF_W-1:0] rand_coeff(input coeff_set_e kind, input int span);
    case (kind)
      SET_AUDIO: return COEFF_W'($urandom_range(2 * span) - span);
      SET_EXTREME: begin
        case ($urandom_range(2))
          0:       return CF_MAX;
          1:       return CF_MIN;
          default: return '0;
        endcase
      end
      default: return COEFF_W'($urandom);
    endcase
  endfunction

  task automatic load_coeff_set(input coeff_set_e kind);
    write_coeff(REG_B0, rand_coeff(kind, 1 << COEFF_FRAC));
    write_coeff(REG_B1, rand_coeff(kind, 1 << (COEFF_FRAC + 1)));
    write_coeff(REG_A1, rand_coeff(kind, 1 << (COEFF_FRAC + 1)));
    write_coeff(REG_B2, rand_coeff(kind, 1 << COEFF_FRAC));
    write_coeff(REG_A2, rand_coeff(kind, 15 << (COEFF_FRAC - 4)));
  endtask

  task automatic test_reset_identity();
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_W'(1), 1'b1);
    send_sample('1, 1'b0);
    send_sample({(SAMPLE_W/2){2'b01}}, 1'b1);
    send_sample({(SAMPLE_W/2){2'b10}}, 1'b0);
    wait_drained();
  endtask

  // half-way ties round up: +0.5 LSB goes to 1, -0.5 LSB goes to 0
  task automatic test_rounding_and_bad_index();
    write_coeff(REG_B0, CF_HALF);
    for (int i = REG_A2 + 1; i <= IDX_TOP; i++) write_coeff(CFG_IDX_W'(i), CF_MIN | 24'h5a5a5);
    send_sample(SAMPLE_W'(1), 1'b0);
    send_sample('1, 1'b1);
    send_sample(SAMPLE_W'(3), 1'b0);
    send_sample(SAMPLE_W'(-3), 1'b1);
    wait_drained();
  endtask

  task automatic test_saturation();
    write_coeff(REG_B0, CF_MAX);
    write_coeff(REG_B1, CF_MAX);
    write_coeff(REG_A1, CF_MIN);
    write_coeff(REG_B2, CF_MAX);
    write_coeff(REG_A2, CF_MIN);
    repeat (4) send_sample(SMP_MAX, 1'b0);
    repeat (3) send_sample(SMP_MIN, 1'b1);
    wait_drained();
    write_coeff(REG_B0, CF_MIN);
    write_coeff(REG_B1, CF_MIN);
    write_coeff(REG_A1, CF_MAX);
    write_coeff(REG_B2, CF_MIN);
    write_coeff(REG_A2, CF_MAX);
    send_sample(SMP_MAX, 1'b1);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    send_sample('0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_filters(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int s = 0; s < SETS_PER_RUN; s++) begin
      load_coeff_set(coeff_set_e'(s % 3));
      repeat (BEATS_PER_SET) send_sample(rand_sample(), $urandom_range(7) == 0);
      wait_drained();
    end
  endtask

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected beat sample=%h last=%b",
                                  m_axis_tdata_o[SAMPLE_W-1:0], m_axis_tlast_o));
      end else begin
        got_beat = pending_outputs.pop_front();
        if (m_axis_tdata_o[SAMPLE_W-1:0] !== got_beat.sample)
          report_mismatch($sformatf("sample_out %h, expected %h",
                                    m_axis_tdata_o[SAMPLE_W-1:0], got_beat.sample));
        if (m_axis_tlast_o !== got_beat.last)
          report_mismatch($sformatf("last_out %b, expected %b",
                                    m_axis_tlast_o, got_beat.last));
      end
    end
  end

  initial begin
    err_count       = 0;
    src_idle_pct    = 16;
    snk_idle_pct    = 74;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    coef_b0         = CF_ONE;
    coef_b1         = '0;
    coef_a1         = '0;
    coef_b2         = '0;
    coef_a2         = '0;
    acc_first       = 0;
    acc_second      = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_identity();
    test_rounding_and_bad_index();
    test_saturation();
    test_random_filters(16, 74);
    test_random_filters(74, 16);
    test_random_filters(0, 0);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
